// File: src/dmc_pkg.sv
// Shared types, codes and address helpers of the direct-mapped cache.
package dmc_pkg;

  localparam int ADDR_BITS = 12;
  localparam int LOG2_BITS = 4;
  localparam int OFFSET_BITS = 8;
  localparam int LINE_BITS = 8;
  localparam int TAG_BITS = 12;

  localparam logic CMD_READ = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NOCFG = 2'd3;

  localparam logic [1:0] REG_ACCEPT = 2'd0;
  localparam logic [1:0] REG_MEM_LOG2 = 2'd1;
  localparam logic [1:0] REG_CACHE_LOG2 = 2'd2;
  localparam logic [1:0] REG_BLOCK_LOG2 = 2'd3;

  typedef struct packed {
    logic                 accepted;
    logic [LOG2_BITS-1:0] mem_log2;
    logic [LOG2_BITS-1:0] cache_log2;
    logic [LOG2_BITS-1:0] block_log2;
  } cfg_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   cmd;
    logic [ADDR_BITS-1:0]   addr;
    logic [OFFSET_BITS-1:0] offset;
    logic [LINE_BITS-1:0]   line;
    logic [TAG_BITS-1:0]    tag;
  } req_t;

  function automatic logic [ADDR_BITS-1:0] low_mask(input logic [LOG2_BITS-1:0] n);
    logic [15:0] m;
    m = (16'd1 << n) - 16'd1;
    return m[ADDR_BITS-1:0];
  endfunction

  function automatic logic [ADDR_BITS-1:0] line_of(input logic [ADDR_BITS-1:0] a,
                                                   input cfg_t c);
    logic [LOG2_BITS-1:0] d;
    d = c.cache_log2 - c.block_log2;
    return (a >> c.block_log2) & low_mask(d);
  endfunction

  function automatic logic [ADDR_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] a,
                                                  input cfg_t c);
    return a >> c.cache_log2;
  endfunction

endpackage

// File: src/dmc_queue.sv
// Two-entry queue between the request front end and the access sequencer.
module dmc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  logic [W-1:0] slots [2];
  logic         wp;
  logic         rp;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data = slots[rp];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_data;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end
endmodule

// File: src/dmc_front.sv
// Front end: configuration registers, request acceptance and classification.
module dmc_front #(
  parameter int MAX_MEM_WORDS = 4096,
  parameter int MAX_CACHE_WORDS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [dmc_pkg::LOG2_BITS-1:0]    cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             cmd,
  input  logic [dmc_pkg::ADDR_BITS-1:0]    address,
  output dmc_pkg::cfg_t                    cfg,
  output logic                             clear_start,
  input  logic                             busy,
  output logic                             q_valid,
  input  logic                             q_ready,
  output dmc_pkg::req_t                    q_req
);
  import dmc_pkg::*;

  localparam int MEM_LOG2_MAX = $clog2(MAX_MEM_WORDS + 1) - 1;
  localparam int CACHE_LOG2_MAX = $clog2(MAX_CACHE_WORDS + 1) - 1;

  logic legal;
  logic in_range;

  assign legal = (cfg.mem_log2 <= LOG2_BITS'(MEM_LOG2_MAX)) &&
                 (cfg.cache_log2 <= LOG2_BITS'(CACHE_LOG2_MAX)) &&
                 (cfg.block_log2 <= cfg.cache_log2);
  assign clear_start = cfg_we && (cfg_index == REG_ACCEPT) && cfg_data[0] && legal;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accepted <= 1'b0;
      cfg.mem_log2 <= LOG2_BITS'(12);
      cfg.cache_log2 <= LOG2_BITS'(8);
      cfg.block_log2 <= LOG2_BITS'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCEPT: cfg.accepted <= cfg_data[0] && legal;
        REG_MEM_LOG2: begin
          cfg.mem_log2 <= cfg_data;
          cfg.accepted <= 1'b0;
        end
        REG_CACHE_LOG2: begin
          cfg.cache_log2 <= cfg_data;
          cfg.accepted <= 1'b0;
        end
        REG_BLOCK_LOG2: begin
          cfg.block_log2 <= cfg_data;
          cfg.accepted <= 1'b0;
        end
        default: cfg.accepted <= cfg.accepted;
      endcase
    end
  end

  assign in_range = ((address >> cfg.mem_log2) == '0);
  assign in_ready = q_ready && !busy && !clear_start;
  assign q_valid = in_valid && !busy && !clear_start;

  always_comb begin
    q_req = '0;
    q_req.cmd = cmd;
    q_req.addr = address;
    if (!cfg.accepted) begin
      q_req.status = ST_NOCFG;
    end else if (!in_range) begin
      q_req.status = ST_RANGE;
    end else begin
      q_req.status = ST_HIT;
      q_req.offset = OFFSET_BITS'(address & low_mask(cfg.block_log2));
      q_req.line = LINE_BITS'(line_of(address, cfg));
      q_req.tag = TAG_BITS'(tag_of(address, cfg));
    end
  end
endmodule

// File: src/dmc_back.sv
// Back end: tag check, block fill, write-through and memory initialization.
module dmc_back #(
  parameter int MAX_MEM_WORDS = 4096,
  parameter int MAX_CACHE_WORDS = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dmc_pkg::cfg_t                      cfg,
  input  logic                               clear_start,
  output logic                               busy,
  input  logic                               q_valid,
  output logic                               q_ready,
  input  dmc_pkg::req_t                      q_req,
  input  logic [WORD_BITS-1:0]               q_wval,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [dmc_pkg::OFFSET_BITS-1:0]    word_offset,
  output logic [dmc_pkg::LINE_BITS-1:0]      line_index,
  output logic [dmc_pkg::TAG_BITS-1:0]       tag,
  output logic signed [WORD_BITS-1:0]        word_value
);
  import dmc_pkg::*;

  localparam int MA = $clog2(MAX_MEM_WORDS);
  localparam int CA = (MAX_CACHE_WORDS > 1) ? $clog2(MAX_CACHE_WORDS) : 1;
  localparam int SW = ADDR_BITS + CA + 2;

  typedef enum logic [2:0] {
    B_IDLE, B_TAG, B_FILL, B_ACCESS, B_READ, B_OUT, B_CLEAR
  } state_t;

  state_t               state;
  req_t                 it;
  logic [WORD_BITS-1:0] it_wval;
  logic [1:0]           res_status;
  logic [WORD_BITS-1:0] res_value;
  logic [CA:0]          rd_k;
  logic [CA:0]          wr_k;
  logic                 pend;
  logic                 wr_ok;
  logic [MA:0]          clr_i;
  logic [MA:0]          clr_words;

  logic [WORD_BITS-1:0] main_mem [MAX_MEM_WORDS];
  logic [WORD_BITS-1:0] cache_mem [MAX_CACHE_WORDS];
  logic [TAG_BITS-1:0]  tag_mem [MAX_CACHE_WORDS];
  logic                 line_valid [MAX_CACHE_WORDS];

  logic                 mem_we;
  logic [MA-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic [MA-1:0]        mem_ra;
  logic [WORD_BITS-1:0] mem_rd;
  logic                 cache_we;
  logic [CA-1:0]        cache_wa;
  logic [WORD_BITS-1:0] cache_wd;
  logic [CA-1:0]        cache_ra;
  logic [WORD_BITS-1:0] cache_rd;
  logic                 tag_we;
  logic [CA-1:0]        tag_ra;
  logic [TAG_BITS-1:0]  tag_rd;

  logic [CA-1:0]        cmask;
  logic [CA-1:0]        bmask;
  logic [CA-1:0]        cidx;
  logic [CA-1:0]        line_i;
  logic [TAG_BITS-1:0]  tag_full;
  logic [CA:0]          blk_words;
  logic [ADDR_BITS-1:0] base;
  logic [SW-1:0]        src;
  logic                 src_ok;
  logic                 hit;

  assign cmask = CA'(low_mask(cfg.cache_log2));
  assign bmask = CA'(low_mask(cfg.block_log2));
  assign cidx = CA'(it.addr) & cmask;
  assign line_i = CA'(line_of(it.addr, cfg));
  assign tag_full = TAG_BITS'(tag_of(it.addr, cfg));
  assign blk_words = (CA + 1)'(1) << cfg.block_log2;
  assign base = it.addr & ~low_mask(cfg.block_log2);
  assign src = SW'(base) + SW'(rd_k);
  assign src_ok = ((src >> cfg.mem_log2) == '0);
  assign hit = line_valid[line_i] && (tag_rd == tag_full);
  assign busy = (state == B_CLEAR);
  assign q_ready = (state == B_IDLE) && !clear_start;
  assign tag_ra = (state == B_IDLE) ? CA'(q_req.line) : line_i;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = MA'(it.addr);
    mem_wd = it_wval;
    mem_ra = MA'(src);
    cache_we = 1'b0;
    cache_wa = cidx;
    cache_wd = it_wval;
    cache_ra = cidx;
    tag_we = 1'b0;
    case (state)
      B_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = MA'(clr_i);
        mem_wd = (clr_i < clr_words) ? WORD_BITS'(clr_words - clr_i) : '0;
      end
      B_FILL: begin
        if (pend) begin
          cache_we = 1'b1;
          cache_wa = (cidx & ~bmask) + CA'(wr_k);
          cache_wd = wr_ok ? mem_rd : '0;
        end
        if ((rd_k == blk_words) && !pend) begin
          tag_we = 1'b1;
        end
      end
      B_ACCESS: begin
        if (it.cmd == CMD_WRITE) begin
          mem_we = 1'b1;
          cache_we = 1'b1;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      main_mem[mem_wa] <= mem_wd;
    end
    mem_rd <= main_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_mem[cache_wa] <= cache_wd;
    end
    cache_rd <= cache_mem[cache_ra];
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[line_i] <= tag_full;
    end
    tag_rd <= tag_mem[tag_ra];
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_CACHE_WORDS; j++) begin
      if (rst || clear_start) begin
        line_valid[j] <= 1'b0;
      end else if (tag_we && (line_i == CA'(j))) begin
        line_valid[j] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != B_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (clear_start) begin
            clr_i <= '0;
            clr_words <= (MA + 1)'(1) << cfg.mem_log2;
            state <= B_CLEAR;
          end else if (q_valid) begin
            it <= q_req;
            it_wval <= q_wval;
            res_status <= q_req.status;
            res_value <= '0;
            if ((q_req.status == ST_NOCFG) || (q_req.status == ST_RANGE)) begin
              state <= B_OUT;
            end else begin
              state <= B_TAG;
            end
          end
        end
        B_CLEAR: begin
          clr_i <= clr_i + 1'b1;
          if (clr_i == (MA + 1)'(MAX_MEM_WORDS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_TAG: begin
          if (hit) begin
            res_status <= ST_HIT;
            state <= B_ACCESS;
          end else begin
            res_status <= ST_MISS;
            rd_k <= '0;
            pend <= 1'b0;
            state <= B_FILL;
          end
        end
        B_FILL: begin
          if (rd_k != blk_words) begin
            wr_k <= rd_k;
            wr_ok <= src_ok;
            pend <= 1'b1;
            rd_k <= rd_k + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= B_ACCESS;
            end
          end
        end
        B_ACCESS: begin
          if (it.cmd == CMD_WRITE) begin
            res_value <= it_wval;
            state <= B_OUT;
          end else begin
            state <= B_READ;
          end
        end
        B_READ: begin
          res_value <= cache_rd;
          state <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= res_status;
            word_offset <= it.offset;
            line_index <= it.line;
            tag <= it.tag;
            word_value <= res_value;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

// File: src/direct_mapped_write_through_cache.sv
// Top level of the direct-mapped, write-through, write-allocate cache.
// Requests enter on the in channel (valid/ready) as a command, a word address and
// a write value; each one produces exactly one result beat on the out channel.
// The front end classifies each request and places it in a two-entry queue; the
// back end sequences the tag check, block fill and write-through to main memory.
// A read hit passes the queue, the registered tag read and the registered cache read
// before it reaches the output register; a write hit skips the cache read.
// A miss adds the block fill, which reads the whole block from main memory, one word per cycle.
// Rejected requests skip the tag check and go straight to the output. Items are processed one at a time.
// Configuration is written through cfg_we, cfg_index and cfg_data. Accepting legal
// sizes clears all line valid bits and starts an initialization pass over all of main
// memory, during which in_ready is low.
// After reset the block is not configured and every request returns status 3.
// When the receiver stalls, the finished result waits in the output register while
// the front end keeps accepting requests until the queue is full.
module direct_mapped_write_through_cache #(
  parameter int MAX_MEM_WORDS = 4096,
  parameter int MAX_CACHE_WORDS = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [dmc_pkg::LOG2_BITS-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic [dmc_pkg::ADDR_BITS-1:0]      address,
  input  logic signed [WORD_BITS-1:0]        write_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [dmc_pkg::OFFSET_BITS-1:0]    word_offset,
  output logic [dmc_pkg::LINE_BITS-1:0]      line_index,
  output logic [dmc_pkg::TAG_BITS-1:0]       tag,
  output logic signed [WORD_BITS-1:0]        word_value
);
  import dmc_pkg::*;

  localparam int QW = $bits(req_t) + WORD_BITS;

  cfg_t                 cfg;
  logic                 clear_start;
  logic                 busy;
  logic                 f_valid;
  logic                 f_ready;
  req_t                 f_req;
  logic                 b_valid;
  logic                 b_ready;
  logic [QW-1:0]        b_data;
  req_t                 b_req;
  logic [WORD_BITS-1:0] b_wval;

  dmc_front #(
    .MAX_MEM_WORDS(MAX_MEM_WORDS),
    .MAX_CACHE_WORDS(MAX_CACHE_WORDS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .address(address),
    .cfg(cfg),
    .clear_start(clear_start),
    .busy(busy),
    .q_valid(f_valid),
    .q_ready(f_ready),
    .q_req(f_req)
  );

  dmc_queue #(
    .W(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data({f_req, write_value}),
    .pop_valid(b_valid),
    .pop_ready(b_ready),
    .pop_data(b_data)
  );

  assign b_req = b_data[QW-1:WORD_BITS];
  assign b_wval = b_data[WORD_BITS-1:0];

  dmc_back #(
    .MAX_MEM_WORDS(MAX_MEM_WORDS),
    .MAX_CACHE_WORDS(MAX_CACHE_WORDS),
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .clear_start(clear_start),
    .busy(busy),
    .q_valid(b_valid),
    .q_ready(b_ready),
    .q_req(b_req),
    .q_wval(b_wval),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .word_offset(word_offset),
    .line_index(line_index),
    .tag(tag),
    .word_value(word_value)
  );
endmodule
